[sv/tew_pkg.sv]
// Shared constants and types for the triangle edge walker.
// Used by the lane and the top level.
package tew_pkg;

	localparam int Q_W       = 32;   // signed Q16.16 word
	localparam int FRAC_W    = 16;   // fraction bits
	localparam int NUM_LANES = 4;    // x, z, w, light
	localparam int DIV_STEPS = 32;   // quotient bits produced one per cycle
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// request opcodes
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} tew_op_t;

	// per-cycle control broadcast to every lane
	typedef struct packed {
		logic load;    // new edge: take start value and set up the divider
		logic flat;    // zero-height edge: slope forced to zero
		logic iter;    // one restoring-division step
		logic finish;  // sign and saturate the quotient into the slope
		logic step;    // add slope to accumulator, saturating
	} tew_lane_ctrl_t;

endpackage

[sv/tew_req_if.sv]
// Request channel of the edge walker: valid/ready plus endpoint fields.
// Depends on no other file.
interface tew_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] start_z;
	logic signed [31:0] start_w;
	logic signed [31:0] start_light;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic signed [31:0] end_z;
	logic signed [31:0] end_w;
	logic signed [31:0] end_light;

	modport source (
		output valid, opcode, start_x, start_y, start_z, start_w, start_light,
		output end_x, end_y, end_z, end_w, end_light,
		input  ready
	);
	modport sink (
		input  valid, opcode, start_x, start_y, start_z, start_w, start_light,
		input  end_x, end_y, end_z, end_w, end_light,
		output ready
	);
endinterface

[sv/tew_rsp_if.sv]
// Result channel of the edge walker: valid/ready plus current edge values.
// Depends on no other file.
interface tew_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cur_x;
	logic signed [31:0] cur_z;
	logic signed [31:0] cur_w;
	logic signed [31:0] cur_light;
	logic signed [31:0] edge_top_y;
	logic signed [31:0] edge_bottom_y;
	logic               flat_edge;

	modport source (
		output valid, cur_x, cur_z, cur_w, cur_light, edge_top_y, edge_bottom_y,
		output flat_edge,
		input  ready
	);
	modport sink (
		input  valid, cur_x, cur_z, cur_w, cur_light, edge_top_y, edge_bottom_y,
		input  flat_edge,
		output ready
	);
endinterface

[sv/tew_lane.sv]
// One interpolation lane: serial restoring divider for the slope plus the
// saturating accumulator. Depends on tew_pkg for widths and the control struct.
module tew_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tew_pkg::tew_lane_ctrl_t            ctrl,
	input  logic signed [tew_pkg::Q_W-1:0]     start_val,
	input  logic signed [tew_pkg::Q_W-1:0]     end_val,
	input  logic        [tew_pkg::Q_W-1:0]     den_mag,
	input  logic                               den_neg,
	output logic signed [tew_pkg::Q_W-1:0]     acc
);

	localparam int W  = tew_pkg::Q_W;
	localparam int FW = tew_pkg::FRAC_W;

	logic [W:0]      diff;
	logic [W:0]      diff_neg;
	logic [W-1:0]    num_mag;
	logic            ovf;
	logic [W:0]      trial;
	logic [W-1:0]    q_neg;
	logic [W-1:0]    slope_nx;
	logic [W:0]      sum;

	logic [W-1:0]    acc_q;
	logic [W-1:0]    slope_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    dvd_q;
	logic [W-1:0]    d_q;
	logic            neg_q;
	logic            ovf_q;

	// numerator magnitude; end - start is exact in W+1 bits, |.| fits in W
	assign diff     = {end_val[W-1], end_val} - {start_val[W-1], start_val};
	assign diff_neg = -diff;
	assign num_mag  = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];

	// quotient of (num << FW) / den reaches 2^W exactly when num >= den << FW
	assign ovf = {{FW{1'b0}}, num_mag} >= {den_mag, {FW{1'b0}}};

	// restoring step: remainder shifted with next dividend bit, minus divisor
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, d_q};

	// signed, saturated Q16.16 slope from the unsigned quotient
	assign q_neg = -dvd_q;
	always_comb begin
		priority if (ovf_q) begin
			slope_nx = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else if (neg_q) begin
			slope_nx = (dvd_q > {1'b1, {(W-1){1'b0}}}) ? {1'b1, {(W-1){1'b0}}} : q_neg;
		end else begin
			slope_nx = dvd_q[W-1] ? {1'b0, {(W-1){1'b1}}} : dvd_q;
		end
	end

	// saturating accumulate
	assign sum = {acc_q[W-1], acc_q} + {slope_q[W-1], slope_q};

	// architectural state: accumulator and slope
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			slope_q <= '0;
		end else begin
			if (ctrl.load) begin
				acc_q <= start_val;
				if (ctrl.flat) begin
					slope_q <= '0;
				end
			end else if (ctrl.step) begin
				if (sum[W] != sum[W-1]) begin
					acc_q <= sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
				end else begin
					acc_q <= sum[W-1:0];
				end
			end
			if (ctrl.finish) begin
				slope_q <= slope_nx;
			end
		end
	end

	// divider datapath; quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= {{(W-FW){1'b0}}, num_mag[W-1:FW]};
			dvd_q <= {num_mag[FW-1:0], {(W-FW){1'b0}}};
			d_q   <= den_mag;
			neg_q <= diff[W] ^ den_neg;
			ovf_q <= ovf;
		end else if (ctrl.iter) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				dvd_q <= {dvd_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
				dvd_q <= {dvd_q[W-2:0], 1'b0};
			end
		end
	end

	assign acc = acc_q;

endmodule

[sv/triangle_edge_walker_unit.sv]
// Top level of the triangle edge walker: sequencer, four lanes and the
// result register. Depends on tew_pkg, tew_req_if, tew_rsp_if and tew_lane.
//
// Usage:
//   req (sink): one request per edge start (opcode 0, both endpoints) or per
//   scanline step (opcode 1, endpoint fields ignored). Taken when valid and
//   ready are high at a rising edge of clk.
//   rsp (source): exactly one result per request, in request order: current
//   x, z, w, light, the stored top and bottom y and the flat-edge flag.
// Sequence:
//   Step: the request goes to ST_EMIT, which loads the result register.
//   Start: the four slopes are divided in parallel lanes, each by a shared-
//   control restoring divider giving one quotient bit per cycle; the lanes
//   run 32 division steps (ST_DIV) and one step to sign and saturate
//   (ST_FIN); ST_EMIT then loads the result register. A zero-height start
//   skips the division. One request is in flight at a time; ready is high
//   only while idle, so no new request is taken until a result is loaded.
// Stall: the result register holds while rsp.ready is low; the next request
//   is still taken and worked, and waits to be loaded until the slot frees.
// Reset: arst_n clears slopes, accumulators, y limits and the flag to zero.
module triangle_edge_walker_unit (
	input  logic       clk,
	input  logic       arst_n,
	tew_req_if.sink    req,
	tew_rsp_if.source  rsp
);

	localparam int W  = tew_pkg::Q_W;
	localparam int NL = tew_pkg::NUM_LANES;
	localparam int CW = tew_pkg::CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic                    out_valid_q;
	logic [W-1:0]            top_y_q;
	logic [W-1:0]            bot_y_q;
	logic                    flat_q;
	logic [W-1:0]            o_acc_q [NL];
	logic [W-1:0]            o_top_q;
	logic [W-1:0]            o_bot_q;
	logic                    o_flat_q;

	logic                    req_take;
	logic                    is_start;
	logic                    is_flat;
	logic                    emit_go;
	logic                    div_last;
	logic [W:0]              height;
	logic [W:0]              height_neg;
	logic [W-1:0]            den_mag;
	tew_pkg::tew_lane_ctrl_t lane_ctrl;
	logic signed [W-1:0]     lane_start [NL];
	logic signed [W-1:0]     lane_end   [NL];
	logic signed [W-1:0]     lane_acc   [NL];

	// request decode
	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;
	assign is_start  = (tew_pkg::tew_op_t'(req.opcode) == tew_pkg::OP_START);
	assign is_flat   = (req.start_y == req.end_y);
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);
	assign div_last  = (cnt_q == CW'(tew_pkg::DIV_STEPS - 1));

	// edge height magnitude and sign, shared by all lanes
	assign height     = {req.end_y[W-1], req.end_y} - {req.start_y[W-1], req.start_y};
	assign height_neg = -height;
	assign den_mag    = height[W] ? height_neg[W-1:0] : height[W-1:0];

	// lane control
	always_comb begin
		lane_ctrl.load   = req_take && is_start;
		lane_ctrl.flat   = is_flat;
		lane_ctrl.iter   = (state_q == ST_DIV);
		lane_ctrl.finish = (state_q == ST_FIN);
		lane_ctrl.step   = req_take && !is_start;
	end

	// channel order x, z, w, light
	assign lane_start[0] = req.start_x;
	assign lane_start[1] = req.start_z;
	assign lane_start[2] = req.start_w;
	assign lane_start[3] = req.start_light;
	assign lane_end[0]   = req.end_x;
	assign lane_end[1]   = req.end_z;
	assign lane_end[2]   = req.end_w;
	assign lane_end[3]   = req.end_light;

	for (genvar i = 0; i < NL; i++) begin : g_lane
		tew_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (lane_ctrl),
			.start_val (lane_start[i]),
			.end_val   (lane_end[i]),
			.den_mag   (den_mag),
			.den_neg   (height[W]),
			.acc       (lane_acc[i])
		);
	end

	// sequencer, edge limits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			top_y_q     <= '0;
			bot_y_q     <= '0;
			flat_q      <= 1'b0;
			for (int i = 0; i < NL; i++) begin
				o_acc_q[i] <= '0;
			end
			o_top_q     <= '0;
			o_bot_q     <= '0;
			o_flat_q    <= 1'b0;
		end else begin
			// slot empties on acceptance unless a new result refills it
			if (rsp.valid && rsp.ready && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						cnt_q <= '0;
						if (is_start) begin
							top_y_q <= req.start_y;
							bot_y_q <= req.end_y;
							flat_q  <= is_flat;
							state_q <= is_flat ? ST_EMIT : ST_DIV;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						for (int i = 0; i < NL; i++) begin
							o_acc_q[i] <= lane_acc[i];
						end
						o_top_q     <= top_y_q;
						o_bot_q     <= bot_y_q;
						o_flat_q    <= flat_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result channel
	assign rsp.valid         = out_valid_q;
	assign rsp.cur_x         = o_acc_q[0];
	assign rsp.cur_z         = o_acc_q[1];
	assign rsp.cur_w         = o_acc_q[2];
	assign rsp.cur_light     = o_acc_q[3];
	assign rsp.edge_top_y    = o_top_q;
	assign rsp.edge_bottom_y = o_bot_q;
	assign rsp.flat_edge     = o_flat_q;

	// a step needs no division
	a_step_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && !is_start |=> state_q == ST_EMIT)
		else $error("step request did not go straight to result");

	// a sloped start begins the division with a cleared counter
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && is_start && !is_flat |=> state_q == ST_DIV && cnt_q == '0)
		else $error("start request did not enter division");

	// division ends after the last quotient bit
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_last |=> state_q == ST_FIN)
		else $error("division overran its step count");

	// a zero-height start records the flag
	a_flat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && is_start && is_flat |=> flat_q && state_q == ST_EMIT)
		else $error("flat edge not flagged");

	// loading the result frees the block for the next request
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> out_valid_q && req.ready)
		else $error("result load did not return to idle");

endmodule
